>>> hdl/rrq_pkg.sv
// shared types and constants for the round robin event queues
`default_nettype none
package rrq_pkg;

    localparam int MAX_QUEUES    = 8;
    localparam int QID_W         = 3;
    localparam int CFG_W         = 4;
    localparam int SRC_W         = 4;
    localparam int PAYLOAD_WIDTH = 32;

    localparam logic [SRC_W-1:0] STACK_SOURCE = 4'd8;

    // operation codes
    localparam logic [1:0] FUNC_PUSH_Q = 2'd0;
    localparam logic [1:0] FUNC_PUSH_S = 2'd1;
    localparam logic [1:0] FUNC_FETCH  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_QUEUE = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // decision of the scheduler for one operation
    typedef struct packed {
        logic             ev_valid;
        logic [SRC_W-1:0] source;
        logic [1:0]       status;
        logic             from_stack;
        logic             need_read;
    } t_result;

endpackage
`default_nettype wire

>>> hdl/rrq_ram.sv
// simple dual port ram with registered read data
`default_nettype none
module rrq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hdl/rrq_sched.sv
// queue pointers, stack count, round robin search and per-operation decision
`default_nettype none
module rrq_sched import rrq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int STACK_DEPTH = 8,
    localparam int HP_W  = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
    localparam int QA_W  = $clog2(MAX_QUEUES * QUEUE_DEPTH),
    localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
    localparam int SC_W  = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [1:0]       i_func,
    input  wire logic [QID_W-1:0] i_queue_id,
    input  wire logic [CFG_W-1:0] i_queues_in_use,
    output t_result               o_res,
    output logic                  o_q_we,
    output logic                  o_q_re,
    output logic      [QA_W-1:0]  o_q_addr,
    output logic                  o_s_we,
    output logic                  o_s_re,
    output logic      [SA_W-1:0]  o_s_addr
);

    logic [HP_W-1:0]  r_head [MAX_QUEUES];
    logic [HP_W-1:0]  r_tail [MAX_QUEUES];
    logic [CNT_W-1:0] r_cnt  [MAX_QUEUES];
    logic [SC_W-1:0]  r_sc;
    logic [QID_W-1:0] r_ptr;

    logic [CFG_W-1:0] act_cnt;
    logic [MAX_QUEUES-1:0] nonempty;
    logic [QID_W-1:0] start;
    logic             found_hi, found_lo, found;
    logic [QID_W-1:0] q_hi, q_lo, sel;
    logic [CFG_W-1:0] sel_p1;
    logic [SC_W-1:0]  sc_dec;
    logic [QA_W-1:0]  wr_addr, rd_addr;
    logic             is_fetch;

    always_comb begin
        act_cnt = (i_queues_in_use > CFG_W'(MAX_QUEUES)) ? CFG_W'(MAX_QUEUES)
                                                         : i_queues_in_use;
        for (int q = 0; q < MAX_QUEUES; q++) begin
            nonempty[q] = (r_cnt[q] != '0) && (CFG_W'(q) < act_cnt);
        end
        // a stale pointer restarts the search at queue zero
        start = ({1'b0, r_ptr} < act_cnt) ? r_ptr : '0;
        found_hi = 1'b0;
        found_lo = 1'b0;
        q_hi     = '0;
        q_lo     = '0;
        for (int q = MAX_QUEUES - 1; q >= 0; q--) begin
            if (nonempty[q] && (QID_W'(q) >= start)) begin
                found_hi = 1'b1;
                q_hi     = QID_W'(q);
            end
            if (nonempty[q]) begin
                found_lo = 1'b1;
                q_lo     = QID_W'(q);
            end
        end
        found  = found_hi | found_lo;
        sel    = found_hi ? q_hi : q_lo;
        sel_p1 = {1'b0, sel} + 1'b1;
        sc_dec = r_sc - 1'b1;
        wr_addr = QA_W'(QA_W'(i_queue_id) * QA_W'(QUEUE_DEPTH)) + QA_W'(r_tail[i_queue_id]);
        rd_addr = QA_W'(QA_W'(sel) * QA_W'(QUEUE_DEPTH)) + QA_W'(r_head[sel]);
    end

    always_comb begin
        o_res    = '0;
        o_q_we   = 1'b0;
        o_q_re   = 1'b0;
        o_s_we   = 1'b0;
        o_s_re   = 1'b0;
        o_s_addr = r_sc[SA_W-1:0];
        is_fetch = (i_func == FUNC_FETCH);
        unique case (i_func)
            FUNC_PUSH_Q: begin
                if ({1'b0, i_queue_id} >= act_cnt) begin
                    o_res.status = ST_BAD_QUEUE;
                end else if (r_cnt[i_queue_id] == CNT_W'(QUEUE_DEPTH)) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_q_we = i_go;
                end
            end
            FUNC_PUSH_S: begin
                if (r_sc == SC_W'(STACK_DEPTH)) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_s_we = i_go;
                end
            end
            FUNC_FETCH: begin
                if (r_sc != '0) begin
                    o_s_re           = i_go;
                    o_s_addr         = sc_dec[SA_W-1:0];
                    o_res.ev_valid   = 1'b1;
                    o_res.source     = STACK_SOURCE;
                    o_res.from_stack = 1'b1;
                    o_res.need_read  = 1'b1;
                end else if (found) begin
                    o_q_re          = i_go;
                    o_res.ev_valid  = 1'b1;
                    o_res.source    = {1'b0, sel};
                    o_res.need_read = 1'b1;
                end else begin
                    o_res.status = ST_EMPTY;
                end
            end
            FUNC_CLEAR: begin
                o_res.status = ST_OK;
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase
        o_q_addr = is_fetch ? rd_addr : wr_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < MAX_QUEUES; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
                r_cnt[q]  <= '0;
            end
            r_sc  <= '0;
            r_ptr <= '0;
        end else if (i_go) begin
            if (o_q_we) begin
                r_tail[i_queue_id] <= (r_tail[i_queue_id] == HP_W'(QUEUE_DEPTH - 1))
                                      ? '0 : r_tail[i_queue_id] + 1'b1;
                r_cnt[i_queue_id]  <= r_cnt[i_queue_id] + 1'b1;
            end
            if (o_s_we) begin
                r_sc <= r_sc + 1'b1;
            end
            if (o_s_re) begin
                r_sc <= sc_dec;
            end
            if (o_q_re) begin
                r_head[sel] <= (r_head[sel] == HP_W'(QUEUE_DEPTH - 1))
                               ? '0 : r_head[sel] + 1'b1;
                r_cnt[sel]  <= r_cnt[sel] - 1'b1;
                r_ptr       <= (sel_p1 >= act_cnt) ? '0 : sel_p1[QID_W-1:0];
            end
            if (i_func == FUNC_CLEAR) begin
                for (int q = 0; q < MAX_QUEUES; q++) begin
                    r_head[q] <= '0;
                    r_tail[q] <= '0;
                    r_cnt[q]  <= '0;
                end
            end
        end
    end

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sc <= SC_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_stack_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_res.from_stack) |=>
            (r_ptr == $past(r_ptr)) && (r_sc == $past(sc_dec)))
        else $error("stack pop disturbed pointer or count");

endmodule
`default_nettype wire

>>> hdl/round_robin_event_queues.sv
// top level of the round robin event queues with a front stack
// channels: input beats (func, queue id, payload), result beats, config beats.
// one result beat per input beat, in order. an input beat is taken while
// o_in_ready is high; o_in_ready stays high while no read is pending and
// the result register is empty or being drained in the same cycle.
// timing: the result of a push, a clear or an empty fetch appears in the
// cycle after acceptance. a fetch that returns an event first does the
// synchronous read of the queue or stack ram and then loads the result
// register; o_in_ready is low during the read cycle.
// the config port is always ready and takes the active queue count; write it
// only while no beat is in flight.
// reset clears the queue pointers and counts, the stack count, the round
// robin pointer and the active queue count; the rams are not cleared, as
// only written entries are ever read.
// when the receiver stalls the result stays in the output register and
// no new beat is taken until it drains.
`default_nettype none
module round_robin_event_queues import rrq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int STACK_DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_func,
    input  wire logic [QID_W-1:0]         i_queue_id,
    input  wire logic [PAYLOAD_WIDTH-1:0] i_event_payload,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_W-1:0]         i_cfg_data,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic                          o_event_valid,
    output logic      [PAYLOAD_WIDTH-1:0] o_event_out,
    output logic      [SRC_W-1:0]         o_source,
    output logic      [1:0]               o_status
);

    localparam int QA_W = $clog2(MAX_QUEUES * QUEUE_DEPTH);
    localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [CFG_W-1:0]         r_cfg;
    logic                     r_busy;
    logic                     r_out_valid;
    t_result                  r_pend;
    logic                     r_event_valid;
    logic [PAYLOAD_WIDTH-1:0] r_event_out;
    logic [SRC_W-1:0]         r_source;
    logic [1:0]               r_status;

    logic                     go;
    t_result                  res;
    logic                     q_we, q_re, s_we, s_re;
    logic [QA_W-1:0]          q_addr;
    logic [SA_W-1:0]          s_addr;
    logic [PAYLOAD_WIDTH-1:0] q_rdata, s_rdata;

    // taken when no read is pending and the result register frees up
    assign o_in_ready  = !r_busy && (!r_out_valid || i_out_ready);
    assign go          = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    rrq_sched #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_sched (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (go),
        .i_func          (i_func),
        .i_queue_id      (i_queue_id),
        .i_queues_in_use (r_cfg),
        .o_res           (res),
        .o_q_we          (q_we),
        .o_q_re          (q_re),
        .o_q_addr        (q_addr),
        .o_s_we          (s_we),
        .o_s_re          (s_re),
        .o_s_addr        (s_addr)
    );

    // event words of all queues, queue index times depth plus slot
    rrq_ram #(
        .DEPTH (MAX_QUEUES * QUEUE_DEPTH),
        .WIDTH (PAYLOAD_WIDTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_addr),
        .i_wdata (i_event_payload),
        .i_re    (q_re),
        .i_raddr (q_addr),
        .o_rdata (q_rdata)
    );

    // front stack words
    rrq_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (PAYLOAD_WIDTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_addr),
        .i_wdata (i_event_payload),
        .i_re    (s_re),
        .i_raddr (s_addr),
        .o_rdata (s_rdata)
    );

    // control: pending read flag, result register occupancy, config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (go) begin
                r_busy      <= res.need_read;
                r_out_valid <= !res.need_read;
            end else if (r_busy) begin
                // ram data is out, result register is known to be empty
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_pend <= res;
            if (!res.need_read) begin
                r_event_valid <= 1'b0;
                r_event_out   <= '0;
                r_source      <= '0;
                r_status      <= res.status;
            end
        end else if (r_busy) begin
            r_event_valid <= r_pend.ev_valid;
            r_event_out   <= r_pend.from_stack ? s_rdata : q_rdata;
            r_source      <= r_pend.source;
            r_status      <= r_pend.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_valid = r_event_valid;
    assign o_event_out   = r_event_out;
    assign o_source      = r_source;
    assign o_status      = r_status;

    a_busy_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_out_valid)
        else $error("read pending while result register occupied");

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_out_valid && !r_busy))
        else $error("fetch result not loaded after ram read");

endmodule
`default_nettype wire
